// File: design/actm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// actm_pkg
// Shared constants and types of the adapter current throttle monitor.
// ----------------------------------------------------------------------------
package actm_pkg;

  // window and sample sizing
  localparam int WINDOW_LEN  = 4;
  localparam int SAMPLE_BITS = 10;
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int PCT_BITS    = 7;
  localparam int TICK_BITS   = 8;
  localparam int PHASE_BITS  = 3;
  localparam int HOLD_BITS   = 4;

  // configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 10;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_ON      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ALARM_OFF     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TURBO_MIN     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AC_ASSERT     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AC_RELEASE    = 3'd4;

  // register reset values
  localparam logic [SAMPLE_BITS-1:0] RST_ALARM_ON   = SAMPLE_BITS'(0);
  localparam logic [SAMPLE_BITS-1:0] RST_ALARM_OFF  = SAMPLE_BITS'(0);
  localparam logic [PCT_BITS-1:0]    RST_TURBO_MIN  = PCT_BITS'(40);
  localparam logic [SAMPLE_BITS-1:0] RST_AC_ASSERT  = SAMPLE_BITS'(423);
  localparam logic [SAMPLE_BITS-1:0] RST_AC_RELEASE = SAMPLE_BITS'(396);

  // fixed throttle thresholds
  localparam logic [SAMPLE_BITS-1:0] BATT_ASSERT_LEVEL = SAMPLE_BITS'(512);
  localparam logic [SAMPLE_BITS-1:0] LOW_ASSERT_LEVEL  = SAMPLE_BITS'(409);
  localparam logic [SAMPLE_BITS-1:0] LOW_RELEASE_LEVEL = SAMPLE_BITS'(382);
  localparam logic [PCT_BITS-1:0]    LOW_BATT_PCT      = PCT_BITS'(10);
  localparam logic [PCT_BITS:0]      ALARM_PCT_MARGIN  = (PCT_BITS+1)'(5);

  // tick scheduling
  localparam logic [PHASE_BITS-1:0] PHASE_LAST = PHASE_BITS'(4);
  localparam logic [TICK_BITS-1:0]  ALARM_TICK = TICK_BITS'(200);

  // hold-off loads and limit
  localparam logic [HOLD_BITS-1:0] HOLD_AC_LOAD  = HOLD_BITS'(3);
  localparam logic [HOLD_BITS-1:0] HOLD_LOW_LOAD = HOLD_BITS'(8);
  localparam logic [HOLD_BITS-1:0] HOLD_MAX      = HOLD_BITS'(8);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] alarm_on_level;
    logic [SAMPLE_BITS-1:0] alarm_off_level;
    logic [PCT_BITS-1:0]    turbo_min_battery;
    logic [SAMPLE_BITS-1:0] ac_only_assert_level;
    logic [SAMPLE_BITS-1:0] ac_only_release_level;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] current_sample;
    logic                   system_running;
    logic                   ac_present;
    logic                   battery_present;
    logic [PCT_BITS-1:0]    battery_percent;
    logic                   calibrating;
  } item_t;

  typedef struct packed {
    logic [WINDOW_LEN-1:0][SAMPLE_BITS-1:0] window;
    logic [TICK_BITS-1:0]                   tick_count;
    logic [PHASE_BITS-1:0]                  phase;
    logic [HOLD_BITS-1:0]                   holdoff;
    logic [SAMPLE_BITS-1:0]                 average;
    logic                                   throttle;
    logic                                   gpu;
    logic                                   turbo;
    logic                                   hybrid_alarm;
    logic                                   ac_alarm;
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average_current;
    logic                   throttle_flag;
    logic                   gpu_throttle_flag;
    logic                   turbo_enable;
    logic                   hybrid_alarm;
    logic                   ac_alarm;
    logic                   resume_charger;
  } result_t;

endpackage
`default_nettype wire

// File: design/adapter_current_throttle_monitor.sv
// An accepted input item is held in the input register, then its result item
// is registered in the result register. Throughput: one item per cycle while
// the result side is not stalled; the state register closes the per-tick loop.
// Reset: synchronous, active high; clears window, counters, flags and the
// pipeline, and loads the configuration registers with their defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// adapter_current_throttle_monitor
// Adapter current averaging with throttle hysteresis and periodic alarms.
// ----------------------------------------------------------------------------
module adapter_current_throttle_monitor (
  input  wire                                    clk,
  input  wire                                    rst,
  // configuration write channel
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [actm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  wire [actm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  // input item channel
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire [actm_pkg::SAMPLE_BITS-1:0]        current_sample,
  input  wire                                    system_running,
  input  wire                                    ac_present,
  input  wire                                    battery_present,
  input  wire [actm_pkg::PCT_BITS-1:0]           battery_percent,
  input  wire                                    calibrating,
  // result item channel
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic [actm_pkg::SAMPLE_BITS-1:0]       average_current,
  output logic                                   throttle_flag,
  output logic                                   gpu_throttle_flag,
  output logic                                   turbo_enable,
  output logic                                   hybrid_alarm,
  output logic                                   ac_alarm,
  output logic                                   resume_charger
);

  actm_pkg::cfg_t    cfg;
  actm_pkg::state_t  st;
  actm_pkg::state_t  st_next;
  actm_pkg::item_t   s1_item;
  actm_pkg::result_t res;
  actm_pkg::result_t out_res;
  logic              s1_valid;
  logic              s1_advance;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarm_on_level        <= actm_pkg::RST_ALARM_ON;
      cfg.alarm_off_level       <= actm_pkg::RST_ALARM_OFF;
      cfg.turbo_min_battery     <= actm_pkg::RST_TURBO_MIN;
      cfg.ac_only_assert_level  <= actm_pkg::RST_AC_ASSERT;
      cfg.ac_only_release_level <= actm_pkg::RST_AC_RELEASE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        actm_pkg::REG_ALARM_ON:   cfg.alarm_on_level <= cfg_data;
        actm_pkg::REG_ALARM_OFF:  cfg.alarm_off_level <= cfg_data;
        actm_pkg::REG_TURBO_MIN:
          cfg.turbo_min_battery <= cfg_data[actm_pkg::PCT_BITS-1:0];
        actm_pkg::REG_AC_ASSERT:  cfg.ac_only_assert_level <= cfg_data;
        actm_pkg::REG_AC_RELEASE: cfg.ac_only_release_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.current_sample  <= current_sample;
      s1_item.system_running  <= system_running;
      s1_item.ac_present      <= ac_present;
      s1_item.battery_present <= battery_present;
      s1_item.battery_percent <= battery_percent;
      s1_item.calibrating     <= calibrating;
    end
  end

  // per-tick step logic
  actm_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (s1_item),
    .st_next (st_next),
    .res     (res)
  );

  // monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res <= res;
    end
  end

  assign average_current   = out_res.average_current;
  assign throttle_flag     = out_res.throttle_flag;
  assign gpu_throttle_flag = out_res.gpu_throttle_flag;
  assign turbo_enable      = out_res.turbo_enable;
  assign hybrid_alarm      = out_res.hybrid_alarm;
  assign ac_alarm          = out_res.ac_alarm;
  assign resume_charger    = out_res.resume_charger;

endmodule
`default_nettype wire

// File: design/actm_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// actm_step
// Next-state and result logic for one tick: window average, throttle
// hysteresis and periodic alarm update.
// ----------------------------------------------------------------------------
module actm_step (
  input  wire actm_pkg::state_t  st,
  input  wire actm_pkg::cfg_t    cfg,
  input  wire actm_pkg::item_t   item,
  output actm_pkg::state_t       st_next,
  output actm_pkg::result_t      res
);

  logic [actm_pkg::SUM_BITS-1:0]    sum;
  logic [actm_pkg::SAMPLE_BITS-1:0] avg;
  logic [actm_pkg::HOLD_BITS-1:0]   hold;
  logic [actm_pkg::PCT_BITS:0]      pct_margin;
  logic                             resume;

  // window sum including the new sample
  always_comb begin
    sum = actm_pkg::SUM_BITS'(item.current_sample);
    for (int i = 0; i < actm_pkg::WINDOW_LEN - 1; i++) begin
      sum = sum + actm_pkg::SUM_BITS'(st.window[i]);
    end
    avg = actm_pkg::SAMPLE_BITS'(sum / actm_pkg::WINDOW_LEN);
  end

  // stepped hold-off, saturated
  always_comb begin
    hold = st.holdoff;
    if (hold != '0) begin
      hold = hold - 1'b1;
    end
    if (hold > actm_pkg::HOLD_MAX) begin
      hold = actm_pkg::HOLD_MAX;
    end
  end

  assign pct_margin = {1'b0, item.battery_percent} + actm_pkg::ALARM_PCT_MARGIN;

  // state update on a counted tick
  always_comb begin
    st_next = st;
    resume  = 1'b0;
    if (item.system_running && item.ac_present) begin
      st_next.tick_count = st.tick_count + 1'b1;
      st_next.phase      = (st.phase == actm_pkg::PHASE_LAST) ? '0 : st.phase + 1'b1;
      for (int i = actm_pkg::WINDOW_LEN - 1; i > 0; i--) begin
        st_next.window[i] = st.window[i-1];
      end
      st_next.window[0] = item.current_sample;
      st_next.average   = avg;

      // throttle update every fifth counted tick
      if (st_next.phase == '0) begin
        st_next.holdoff = hold;
        if (!item.battery_present) begin
          if (avg >= cfg.ac_only_assert_level) begin
            st_next.throttle = 1'b1;
            st_next.gpu      = 1'b1;
            st_next.holdoff  = actm_pkg::HOLD_AC_LOAD;
          end else if (avg < cfg.ac_only_release_level && hold == '0) begin
            st_next.throttle = 1'b0;
            st_next.gpu      = 1'b0;
          end
        end else if (item.battery_percent >= actm_pkg::LOW_BATT_PCT) begin
          st_next.throttle = (avg >= actm_pkg::BATT_ASSERT_LEVEL);
          st_next.gpu      = (avg >= actm_pkg::BATT_ASSERT_LEVEL);
        end else begin
          if (avg >= actm_pkg::LOW_ASSERT_LEVEL) begin
            st_next.throttle = 1'b1;
            st_next.holdoff  = actm_pkg::HOLD_LOW_LOAD;
          end else if (avg < actm_pkg::LOW_RELEASE_LEVEL && hold == '0) begin
            st_next.throttle = 1'b0;
          end
          // low battery keeps the gpu request on
          st_next.gpu = 1'b1;
        end
      end

      // alarm update once per alarm period
      if (st_next.tick_count > actm_pkg::ALARM_TICK) begin
        st_next.tick_count = '0;
        st_next.phase      = '0;
        if (item.battery_present) begin
          resume = !item.calibrating;
          if (item.battery_percent > cfg.turbo_min_battery) begin
            st_next.turbo = 1'b1;
          end else begin
            st_next.turbo = 1'b0;
            if (cfg.alarm_on_level != '0 &&
                pct_margin <= {1'b0, cfg.turbo_min_battery}) begin
              if (avg > cfg.alarm_on_level) begin
                st_next.hybrid_alarm = 1'b1;
              end
              if (avg < cfg.alarm_off_level) begin
                st_next.hybrid_alarm = 1'b0;
              end
            end else begin
              st_next.hybrid_alarm = 1'b0;
            end
          end
        end else begin
          if (avg > cfg.alarm_on_level) begin
            st_next.ac_alarm = 1'b1;
          end
          if (avg < cfg.alarm_off_level) begin
            st_next.ac_alarm = 1'b0;
          end
        end
      end
    end
  end

  // result item from the updated state
  always_comb begin
    res.average_current   = st_next.average;
    res.throttle_flag     = st_next.throttle;
    res.gpu_throttle_flag = st_next.gpu;
    res.turbo_enable      = st_next.turbo;
    res.hybrid_alarm      = st_next.hybrid_alarm;
    res.ac_alarm          = st_next.ac_alarm;
    res.resume_charger    = resume;
  end

endmodule
`default_nettype wire

// File: tb/throttle_monitor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// throttle_monitor_checker
// Watches the configuration, input and result channels of the adapter current
// throttle monitor, predicts each result item from its own copy of the
// averaging window, hold-off counter and flags, and compares every accepted
// result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module throttle_monitor_checker (
  input  wire                                 clk,
  input  wire                                 rst,
  // configuration write channel
  input  wire                                 cfg_valid,
  input  wire                                 cfg_ready,
  input  wire [actm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire [actm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input item channel
  input  wire                                 in_valid,
  input  wire                                 in_ready,
  input  wire [actm_pkg::SAMPLE_BITS-1:0]     current_sample,
  input  wire                                 system_running,
  input  wire                                 ac_present,
  input  wire                                 battery_present,
  input  wire [actm_pkg::PCT_BITS-1:0]        battery_percent,
  input  wire                                 calibrating,
  // result item channel
  input  wire                                 out_valid,
  input  wire                                 out_ready,
  input  wire [actm_pkg::SAMPLE_BITS-1:0]     average_current,
  input  wire                                 throttle_flag,
  input  wire                                 gpu_throttle_flag,
  input  wire                                 turbo_enable,
  input  wire                                 hybrid_alarm,
  input  wire                                 ac_alarm,
  input  wire                                 resume_charger,
  // status to the top
  output int                                  errors,
  output int                                  pending
);

  localparam int THROTTLE_EVERY = 5;
  localparam int PRINT_CAP      = 100;

  // predicted monitor state
  actm_pkg::cfg_t                   levels;
  logic [actm_pkg::SAMPLE_BITS-1:0] samples [actm_pkg::WINDOW_LEN];
  logic [actm_pkg::TICK_BITS-1:0]   tick_count;
  logic [actm_pkg::HOLD_BITS-1:0]   holdoff;
  logic [actm_pkg::SAMPLE_BITS-1:0] average;
  logic                             throttle_on;
  logic                             gpu_on;
  logic                             turbo_on;
  logic                             hybrid_on;
  logic                             ac_alarm_on;

  actm_pkg::result_t predicted_items [$];
  int                mismatch_count;
  int                items_checked;

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns checker: item %0d: %s", $time, items_checked, what);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // throttle and gpu flags, every fifth counted tick
  function automatic void step_throttle(actm_pkg::item_t t);
    if (holdoff != '0) holdoff = holdoff - 1'b1;
    if (holdoff > actm_pkg::HOLD_MAX) holdoff = actm_pkg::HOLD_MAX;
    if (!t.battery_present) begin
      if (average >= levels.ac_only_assert_level) begin
        throttle_on = 1'b1;
        gpu_on      = 1'b1;
        holdoff     = actm_pkg::HOLD_AC_LOAD;
      end else if (average < levels.ac_only_release_level && holdoff == '0) begin
        throttle_on = 1'b0;
        gpu_on      = 1'b0;
      end
    end else if (t.battery_percent >= actm_pkg::LOW_BATT_PCT) begin
      // no hysteresis with a healthy battery
      throttle_on = (average >= actm_pkg::BATT_ASSERT_LEVEL);
      gpu_on      = (average >= actm_pkg::BATT_ASSERT_LEVEL);
    end else begin
      if (average >= actm_pkg::LOW_ASSERT_LEVEL) begin
        throttle_on = 1'b1;
        gpu_on      = 1'b1;
        holdoff     = actm_pkg::HOLD_LOW_LOAD;
      end else if (average < actm_pkg::LOW_RELEASE_LEVEL && holdoff == '0) begin
        throttle_on = 1'b0;
        gpu_on      = 1'b0;
      end
      // low battery keeps the gpu request up regardless
      gpu_on = 1'b1;
    end
  endfunction

  // turbo, charger resume and power alarms; returns the resume pulse
  function automatic logic step_alarms(actm_pkg::item_t t);
    logic resume;
    resume = 1'b0;
    if (t.battery_present) begin
      resume = !t.calibrating;
      if (t.battery_percent > levels.turbo_min_battery) begin
        turbo_on = 1'b1;
      end else begin
        turbo_on = 1'b0;
        if (levels.alarm_on_level != '0 &&
            ({1'b0, t.battery_percent} + actm_pkg::ALARM_PCT_MARGIN) <=
            {1'b0, levels.turbo_min_battery}) begin
          if (average > levels.alarm_on_level) hybrid_on = 1'b1;
          if (average < levels.alarm_off_level) hybrid_on = 1'b0;
        end else begin
          hybrid_on = 1'b0;
        end
      end
    end else begin
      if (average > levels.alarm_on_level) ac_alarm_on = 1'b1;
      if (average < levels.alarm_off_level) ac_alarm_on = 1'b0;
    end
    return resume;
  endfunction

  // advance the predicted state by one tick and form the result item
  function automatic actm_pkg::result_t predict_item(actm_pkg::item_t t);
    logic [actm_pkg::SUM_BITS-1:0] sum;
    actm_pkg::result_t             r;
    r.resume_charger = 1'b0;
    if (t.system_running && t.ac_present) begin
      tick_count = tick_count + 1'b1;
      for (int i = actm_pkg::WINDOW_LEN - 1; i > 0; i--) samples[i] = samples[i-1];
      samples[0] = t.current_sample;
      sum = '0;
      for (int i = 0; i < actm_pkg::WINDOW_LEN; i++)
        sum = sum + actm_pkg::SUM_BITS'(samples[i]);
      average = actm_pkg::SAMPLE_BITS'(sum / actm_pkg::WINDOW_LEN);
      if (int'(tick_count) % THROTTLE_EVERY == 0) step_throttle(t);
      if (tick_count > actm_pkg::ALARM_TICK) begin
        r.resume_charger = step_alarms(t);
        tick_count = '0;
      end
    end
    r.average_current   = average;
    r.throttle_flag     = throttle_on;
    r.gpu_throttle_flag = gpu_on;
    r.turbo_enable      = turbo_on;
    r.hybrid_alarm      = hybrid_on;
    r.ac_alarm          = ac_alarm_on;
    return r;
  endfunction

  // sample all three channels at each rising edge
  always @(posedge clk) begin : watch
    actm_pkg::item_t   seen;
    actm_pkg::result_t got;
    actm_pkg::result_t want;
    if (rst) begin
      levels.alarm_on_level        = actm_pkg::RST_ALARM_ON;
      levels.alarm_off_level       = actm_pkg::RST_ALARM_OFF;
      levels.turbo_min_battery     = actm_pkg::RST_TURBO_MIN;
      levels.ac_only_assert_level  = actm_pkg::RST_AC_ASSERT;
      levels.ac_only_release_level = actm_pkg::RST_AC_RELEASE;
      for (int i = 0; i < actm_pkg::WINDOW_LEN; i++) samples[i] = '0;
      tick_count  = '0;
      holdoff     = '0;
      average     = '0;
      throttle_on = 1'b0;
      gpu_on      = 1'b0;
      turbo_on    = 1'b0;
      hybrid_on   = 1'b0;
      ac_alarm_on = 1'b0;
      predicted_items.delete();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          actm_pkg::REG_ALARM_ON:
            levels.alarm_on_level = cfg_data[actm_pkg::SAMPLE_BITS-1:0];
          actm_pkg::REG_ALARM_OFF:
            levels.alarm_off_level = cfg_data[actm_pkg::SAMPLE_BITS-1:0];
          actm_pkg::REG_TURBO_MIN:
            levels.turbo_min_battery = cfg_data[actm_pkg::PCT_BITS-1:0];
          actm_pkg::REG_AC_ASSERT:
            levels.ac_only_assert_level = cfg_data[actm_pkg::SAMPLE_BITS-1:0];
          actm_pkg::REG_AC_RELEASE:
            levels.ac_only_release_level = cfg_data[actm_pkg::SAMPLE_BITS-1:0];
          default: ;
        endcase
      end
      // result item against the oldest prediction
      if (out_valid && out_ready) begin
        got.average_current   = average_current;
        got.throttle_flag     = throttle_flag;
        got.gpu_throttle_flag = gpu_throttle_flag;
        got.turbo_enable      = turbo_enable;
        got.hybrid_alarm      = hybrid_alarm;
        got.ac_alarm          = ac_alarm;
        got.resume_charger    = resume_charger;
        if (predicted_items.size() == 0) begin
          report_mismatch("result item with no input item waiting for it");
        end else begin
          want = predicted_items.pop_front();
          check_field("average_current", int'(got.average_current),
                      int'(want.average_current));
          check_field("throttle_flag", int'(got.throttle_flag),
                      int'(want.throttle_flag));
          check_field("gpu_throttle_flag", int'(got.gpu_throttle_flag),
                      int'(want.gpu_throttle_flag));
          check_field("turbo_enable", int'(got.turbo_enable),
                      int'(want.turbo_enable));
          check_field("hybrid_alarm", int'(got.hybrid_alarm),
                      int'(want.hybrid_alarm));
          check_field("ac_alarm", int'(got.ac_alarm), int'(want.ac_alarm));
          check_field("resume_charger", int'(got.resume_charger),
                      int'(want.resume_charger));
        end
        items_checked++;
      end
      // new input item
      if (in_valid && in_ready) begin
        seen.current_sample  = current_sample;
        seen.system_running  = system_running;
        seen.ac_present      = ac_present;
        seen.battery_present = battery_present;
        seen.battery_percent = battery_percent;
        seen.calibrating     = calibrating;
        predicted_items.push_back(predict_item(seen));
      end
    end
    pending <= predicted_items.size();
    errors  <= mismatch_count;
  end

endmodule

// File: tb/adapter_current_throttle_monitor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adapter_current_throttle_monitor_tb
// Drives sensor ticks and register writes into the throttle monitor: a short
// directed run through the throttle modes and hold-off cases, then level runs
// around every threshold under several register settings, with random stalls
// on both sides. The checker beside the block predicts and compares items.
// ----------------------------------------------------------------------------
module adapter_current_throttle_monitor_tb;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int TICKS_PER_PHASE  = 80;
  localparam int NUM_PHASES       = 5;
  localparam int SETTLE_CYCLES    = 4;
  localparam int IDLE_PERCENT     = 24;
  localparam int UNCOUNTED_PCT    = 8;
  localparam int ALARM_PERIOD     = 201;
  localparam int SAMPLE_MAX       = (1 << actm_pkg::SAMPLE_BITS) - 1;
  localparam int PCT_MAX          = (1 << actm_pkg::PCT_BITS) - 1;

  typedef logic [actm_pkg::SAMPLE_BITS-1:0] sample_t;
  typedef logic [actm_pkg::PCT_BITS-1:0]    pct_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [actm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [actm_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  sample_t                             current_sample;
  logic                                system_running;
  logic                                ac_present;
  logic                                battery_present;
  pct_t                                battery_percent;
  logic                                calibrating;
  logic                                out_valid;
  logic                                out_ready;
  sample_t                             average_current;
  logic                                throttle_flag;
  logic                                gpu_throttle_flag;
  logic                                turbo_enable;
  logic                                hybrid_alarm;
  logic                                ac_alarm;
  logic                                resume_charger;

  int             errors;
  int             pending;
  int             cycle_count = 0;
  bit             steady;
  actm_pkg::cfg_t live_cfg;
  int             counted_ticks;

  // current level run
  int   level;
  int   spread;
  int   run_left;
  bit   mode_batt;
  bit   mode_cal;
  pct_t mode_pct;

  adapter_current_throttle_monitor DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .current_sample    (current_sample),
    .system_running    (system_running),
    .ac_present        (ac_present),
    .battery_present   (battery_present),
    .battery_percent   (battery_percent),
    .calibrating       (calibrating),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .average_current   (average_current),
    .throttle_flag     (throttle_flag),
    .gpu_throttle_flag (gpu_throttle_flag),
    .turbo_enable      (turbo_enable),
    .hybrid_alarm      (hybrid_alarm),
    .ac_alarm          (ac_alarm),
    .resume_charger    (resume_charger)
  );

  throttle_monitor_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .current_sample    (current_sample),
    .system_running    (system_running),
    .ac_present        (ac_present),
    .battery_present   (battery_present),
    .battery_percent   (battery_percent),
    .calibrating       (calibrating),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .average_current   (average_current),
    .throttle_flag     (throttle_flag),
    .gpu_throttle_flag (gpu_throttle_flag),
    .turbo_enable      (turbo_enable),
    .hybrid_alarm      (hybrid_alarm),
    .ac_alarm          (ac_alarm),
    .resume_charger    (resume_charger),
    .errors            (errors),
    .pending           (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // one register write, held until accepted
  task automatic write_reg(logic [actm_pkg::CFG_INDEX_BITS-1:0] idx,
                           logic [actm_pkg::CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // register settings per phase, the extremes among them
  function automatic actm_pkg::cfg_t settings_for(int phase);
    actm_pkg::cfg_t c;
    case (phase)
      0: begin
        c.alarm_on_level        = actm_pkg::RST_ALARM_ON;
        c.alarm_off_level       = actm_pkg::RST_ALARM_OFF;
        c.turbo_min_battery     = actm_pkg::RST_TURBO_MIN;
        c.ac_only_assert_level  = actm_pkg::RST_AC_ASSERT;
        c.ac_only_release_level = actm_pkg::RST_AC_RELEASE;
      end
      1: begin
        c.alarm_on_level        = sample_t'(500);
        c.alarm_off_level       = sample_t'(300);
        c.turbo_min_battery     = pct_t'(60);
        c.ac_only_assert_level  = sample_t'(450);
        c.ac_only_release_level = sample_t'(350);
      end
      2: begin
        c.alarm_on_level        = sample_t'(SAMPLE_MAX);
        c.alarm_off_level       = sample_t'(SAMPLE_MAX);
        c.turbo_min_battery     = pct_t'(100);
        c.ac_only_assert_level  = sample_t'(SAMPLE_MAX);
        c.ac_only_release_level = sample_t'(SAMPLE_MAX);
      end
      3: begin
        c.alarm_on_level        = sample_t'(1);
        c.alarm_off_level       = sample_t'(0);
        c.turbo_min_battery     = pct_t'(5);
        c.ac_only_assert_level  = sample_t'(0);
        c.ac_only_release_level = sample_t'(0);
      end
      default: begin
        c.alarm_on_level        = sample_t'($urandom_range(0, SAMPLE_MAX));
        c.alarm_off_level       = sample_t'($urandom_range(0, SAMPLE_MAX));
        c.turbo_min_battery     = pct_t'($urandom_range(5, 100));
        c.ac_only_assert_level  = sample_t'($urandom_range(0, SAMPLE_MAX));
        c.ac_only_release_level = sample_t'($urandom_range(0, SAMPLE_MAX));
      end
    endcase
    return c;
  endfunction

  task automatic apply_settings(actm_pkg::cfg_t c);
    write_reg(actm_pkg::REG_ALARM_ON, c.alarm_on_level);
    write_reg(actm_pkg::REG_ALARM_OFF, c.alarm_off_level);
    write_reg(actm_pkg::REG_TURBO_MIN, actm_pkg::CFG_DATA_BITS'(c.turbo_min_battery));
    write_reg(actm_pkg::REG_AC_ASSERT, c.ac_only_assert_level);
    write_reg(actm_pkg::REG_AC_RELEASE, c.ac_only_release_level);
    cfg_valid <= 1'b0;
    live_cfg = c;
  endtask

  // stop sending and let every result item come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one tick item, with random idle cycles ahead of it
  task automatic send_tick(actm_pkg::item_t t);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    current_sample  <= t.current_sample;
    system_running  <= t.system_running;
    ac_present      <= t.ac_present;
    battery_present <= t.battery_present;
    battery_percent <= t.battery_percent;
    calibrating     <= t.calibrating;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (t.system_running && t.ac_present)
      counted_ticks = (counted_ticks + 1) % ALARM_PERIOD;
  endtask

  task automatic send_run(int n, int sample, bit run, bit ac, bit batt, int pct, bit cal);
    actm_pkg::item_t t;
    t.current_sample  = sample_t'(sample);
    t.system_running  = run;
    t.ac_present      = ac;
    t.battery_present = batt;
    t.battery_percent = pct_t'(pct);
    t.calibrating     = cal;
    repeat (n) send_tick(t);
  endtask

  // battery percent: low, normal, out of range, around the turbo limit, or at the low-battery edge
  function automatic pct_t pick_percent();
    int p;
    case ($urandom_range(0, 4))
      0: p = $urandom_range(0, 9);
      1: p = $urandom_range(10, 100);
      2: p = $urandom_range(101, PCT_MAX);
      3: p = int'(live_cfg.turbo_min_battery) + int'($urandom_range(0, 7)) - 6;
      default: p = $urandom_range(9, 10);
    endcase
    if (p < 0) p = 0;
    return pct_t'(p);
  endfunction

  // next random tick: runs of samples around a threshold with a held mode
  task automatic make_random_tick(output actm_pkg::item_t t);
    int s;
    if (run_left == 0) begin
      run_left = $urandom_range(3, 24);
      spread   = $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0: level = int'(live_cfg.ac_only_assert_level);
        1: level = int'(live_cfg.ac_only_release_level);
        2: level = int'(actm_pkg::BATT_ASSERT_LEVEL);
        3: level = int'(actm_pkg::LOW_ASSERT_LEVEL);
        4: level = int'(actm_pkg::LOW_RELEASE_LEVEL);
        5: level = int'(live_cfg.alarm_on_level);
        6: level = int'(live_cfg.alarm_off_level);
        7: level = 0;
        8: level = SAMPLE_MAX;
        default: level = $urandom_range(0, SAMPLE_MAX);
      endcase
      mode_batt = 1'($urandom_range(0, 1));
      mode_cal  = ($urandom_range(0, 3) == 0);
      mode_pct  = pick_percent();
    end
    run_left--;
    s = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (s < 0) s = 0;
    if (s > SAMPLE_MAX) s = SAMPLE_MAX;
    t.current_sample  = sample_t'(s);
    t.battery_present = mode_batt;
    t.battery_percent = mode_pct;
    t.calibrating     = mode_cal;
    t.system_running  = 1'b1;
    t.ac_present      = 1'b1;
    if ($urandom_range(0, 99) < UNCOUNTED_PCT) begin
      // system off or on battery: tick is ignored
      case ($urandom_range(0, 2))
        0: {t.system_running, t.ac_present} = 2'b00;
        1: {t.system_running, t.ac_present} = 2'b01;
        default: {t.system_running, t.ac_present} = 2'b10;
      endcase
      t.current_sample = sample_t'($urandom_range(0, SAMPLE_MAX));
    end else if (counted_ticks == ALARM_PERIOD - 1) begin
      // alarm tick: steer toward the turbo and hybrid alarm branches
      t.battery_present = ($urandom_range(0, 3) != 0);
      t.calibrating     = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 2))
        0: t.battery_percent = live_cfg.turbo_min_battery + 1'b1;
        1: t.battery_percent = (live_cfg.turbo_min_battery >= pct_t'(5)) ?
                               live_cfg.turbo_min_battery - pct_t'(5) : pct_t'(0);
        default: t.battery_percent = pick_percent();
      endcase
    end
  endtask

  // stimulus and verdict
  initial begin
    actm_pkg::item_t t;
    int              done;
    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    current_sample  <= '0;
    system_running  <= 1'b0;
    ac_present      <= 1'b0;
    battery_present <= 1'b0;
    battery_percent <= '0;
    calibrating     <= 1'b0;
    steady        = 1'b0;
    counted_ticks = 0;
    run_left      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) wait_for_results();
      apply_settings(settings_for(phase));
      // one phase with no idling on either side
      steady = (phase == 1);
      if (phase == 0) begin
        // uncounted ticks: system off, AC off, both off
        send_run(1, SAMPLE_MAX, 0, 1, 0, 0, 0);
        send_run(1, SAMPLE_MAX, 1, 0, 1, PCT_MAX, 1);
        send_run(1, 0, 0, 0, 1, 100, 1);
        // AC only, full current: immediate assert with hold-off
        send_run(5, SAMPLE_MAX, 1, 1, 0, 0, 0);
        // current drops: release held off by the counter
        send_run(5, 0, 1, 1, 0, 50, 1);
        // low battery: still held, gpu request forced on
        send_run(5, 0, 1, 1, 1, 9, 0);
        // out-of-range percent counts as healthy battery: clears at once
        send_run(5, 0, 1, 1, 1, PCT_MAX, 1);
      end
      done = 0;
      while (done < TICKS_PER_PHASE) begin
        make_random_tick(t);
        send_tick(t);
        if (t.system_running && t.ac_present) done++;
      end
    end

    wait_for_results();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
